// File: src/qwk_pkg.sv
// qwk_pkg: shared types, constants and label table for the QWK message-to-text block.
// No dependencies; imported by qwk_message_to_text, qwk_front, qwk_cmd_queue and qwk_back.
`default_nettype none

package qwk_pkg;

  localparam int COUNT_BITS = 20;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // header offsets
  localparam logic [6:0] OFF_DATE_S  = 7'd8;
  localparam logic [6:0] OFF_DATE_E  = 7'd15;
  localparam logic [6:0] OFF_TIME_S  = 7'd16;
  localparam logic [6:0] OFF_TIME_E  = 7'd20;
  localparam logic [6:0] OFF_TO_S    = 7'd21;
  localparam logic [6:0] OFF_TO_E    = 7'd45;
  localparam logic [6:0] OFF_FROM_S  = 7'd46;
  localparam logic [6:0] OFF_FROM_E  = 7'd70;
  localparam logic [6:0] OFF_SUBJ_S  = 7'd71;
  localparam logic [6:0] OFF_SUBJ_E  = 7'd95;
  localparam logic [6:0] OFF_CNT_S   = 7'd116;
  localparam logic [6:0] OFF_CNT_E   = 7'd121;
  localparam logic [6:0] OFF_LAST    = 7'd127;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QWKNL = 8'he3;

  typedef enum logic [1:0] {
    PH_FILE   = 2'd0,
    PH_HDR    = 2'd1,
    PH_BODY   = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    PS_SKIP   = 2'd0,
    PS_DIGITS = 2'd1,
    PS_DONE   = 2'd3
  } pstage_t;

  typedef enum logic [2:0] {
    LBL_NONE = 3'd0,
    LBL_DATE = 3'd1,
    LBL_TIME = 3'd2,
    LBL_TO   = 3'd3,
    LBL_FROM = 3'd4,
    LBL_SUBJ = 3'd5
  } lbl_sel_t;

  // one queued command: optional label, optional byte, 0..2 newlines
  typedef struct packed {
    lbl_sel_t   lbl;
    logic       has_byte;
    logic [7:0] data;
    logic [1:0] nl_cnt;
  } cmd_t;

  function automatic logic [2:0] label_len(lbl_sel_t sel);
    logic [2:0] len;
    unique case (sel)
      LBL_DATE, LBL_TIME, LBL_FROM, LBL_SUBJ: len = 3'd6;
      LBL_TO:                                 len = 3'd4;
      default:                                len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] label_char(lbl_sel_t sel, logic [2:0] idx);
    logic [47:0] str;
    logic [7:0]  ch;
    unique case (sel)
      LBL_DATE: str = "Date: ";
      LBL_TIME: str = "Time: ";
      LBL_TO:   str = "To:   ";
      LBL_FROM: str = "From: ";
      LBL_SUBJ: str = "Subj: ";
      default:  str = '0;
    endcase
    case (idx)
      3'd0:    ch = str[47:40];
      3'd1:    ch = str[39:32];
      3'd2:    ch = str[31:24];
      3'd3:    ch = str[23:16];
      3'd4:    ch = str[15:8];
      3'd5:    ch = str[7:0];
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: src/qwk_in_if.sv
// qwk_in_if: input channel, one raw file byte per beat.
// No dependencies.
`default_nettype none

interface qwk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: src/qwk_out_if.sv
// qwk_out_if: result channel, one text byte per beat plus last flag.
// No dependencies.
`default_nettype none

interface qwk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// File: src/qwk_message_to_text.sv
// Top level: QWK message file bytes in, text beats out.
// An accepted byte's command is written into the queue, then loaded into the output register.
// Throughput: one input beat per cycle while the 4-deep command queue has room;
// one output beat per cycle while the output is ready, so a field start emits its label beats first.
// Reset (rst_n low, synchronous) returns to the file-header phase, empties the queue.
// Depends on qwk_pkg, qwk_in_if, qwk_out_if, qwk_front, qwk_cmd_queue, qwk_back.
`default_nettype none

module qwk_message_to_text import qwk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qwk_in_if.sink    in_ch,
  qwk_out_if.source out_ch
);

  // front -> queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;

  // queue -> back
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head_cmd;

  // Front: owns block offset, phase, field-ended flag and the block-count parser.
  // Every accepted beat updates state; only beats that produce text push a command.
  qwk_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push_o (q_push),
    .cmd_o  (q_push_cmd)
  );

  // Queue: decouples byte intake from label bursts on the output side.
  qwk_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  // Back: walks label, data byte and newlines of the head command, one beat
  // per cycle while the output is ready, into the output register; last marks the command's final beat.
  qwk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// File: src/qwk_front.sv
// qwk_front: accepts file bytes, tracks block/field/count state, issues commands.
// Depends on qwk_pkg and qwk_in_if.
`default_nettype none

module qwk_front import qwk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  qwk_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     push_o,
  output cmd_t     cmd_o
);

  phase_t                  phase_r, phase_nxt;
  logic [6:0]              off_r;
  logic                    fend_r, fend_nxt;
  pstage_t                 stage_r, stage_nxt;
  logic                    neg_r, neg_nxt;
  logic [COUNT_BITS-1:0]   acc_r, acc_nxt;
  logic [COUNT_BITS-1:0]   blk_r, blk_nxt;

  logic       accept;
  logic [7:0] b;
  lbl_sel_t   fsel;
  logic       fstart, fendpos, fe;
  logic       is_digit, is_ws;
  pstage_t    stage_e;
  logic                  neg_e;
  logic [COUNT_BITS-1:0] acc_e, blk_calc;
  cmd_t       cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_ws       = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

  // field decode by header offset
  always_comb begin
    case (off_r) inside
      [OFF_DATE_S:OFF_DATE_E]: fsel = LBL_DATE;
      [OFF_TIME_S:OFF_TIME_E]: fsel = LBL_TIME;
      [OFF_TO_S:OFF_TO_E]:     fsel = LBL_TO;
      [OFF_FROM_S:OFF_FROM_E]: fsel = LBL_FROM;
      [OFF_SUBJ_S:OFF_SUBJ_E]: fsel = LBL_SUBJ;
      default:                 fsel = LBL_NONE;
    endcase
  end

  assign fstart  = (off_r == OFF_DATE_S) || (off_r == OFF_TIME_S) || (off_r == OFF_TO_S) ||
                   (off_r == OFF_FROM_S) || (off_r == OFF_SUBJ_S);
  assign fendpos = (off_r == OFF_DATE_E) || (off_r == OFF_TIME_E) || (off_r == OFF_TO_E) ||
                   (off_r == OFF_FROM_E) || (off_r == OFF_SUBJ_E);

  always_comb begin
    phase_nxt = phase_r;
    fend_nxt  = fend_r;
    stage_nxt = stage_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    blk_nxt   = blk_r;
    cmd       = '{lbl: LBL_NONE, has_byte: 1'b0, data: CH_NUL, nl_cnt: 2'd0};
    fe        = fstart ? 1'b0 : fend_r;
    // count field restarts at its first byte
    stage_e   = (off_r == OFF_CNT_S) ? PS_SKIP : stage_r;
    neg_e     = (off_r == OFF_CNT_S) ? 1'b0 : neg_r;
    acc_e     = (off_r == OFF_CNT_S) ? '0 : acc_r;
    blk_calc  = '0;

    unique case (phase_r)
      PH_HDR: begin
        if (fsel != LBL_NONE) begin
          if (fstart) cmd.lbl = fsel;
          fend_nxt = fe || (b == CH_NUL);
          if (!fe && (b != CH_NUL)) begin
            cmd.has_byte = 1'b1;
            cmd.data     = b;
          end
          if (fendpos) cmd.nl_cnt = 2'd1;
        end

        if ((off_r >= OFF_CNT_S) && (off_r <= OFF_CNT_E)) begin
          stage_nxt = stage_e;
          neg_nxt   = neg_e;
          acc_nxt   = acc_e;
          unique case (stage_e)
            PS_SKIP: begin
              if (is_ws) begin
                stage_nxt = PS_SKIP;
              end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
                neg_nxt   = (b == CH_MINUS);
                stage_nxt = PS_DIGITS;
              end else if (is_digit) begin
                acc_nxt   = COUNT_BITS'(b[3:0]);
                stage_nxt = PS_DIGITS;
              end else begin
                stage_nxt = PS_DONE;
              end
            end
            PS_DIGITS: begin
              if (is_digit) begin
                acc_nxt = (acc_e << 3) + (acc_e << 1) + COUNT_BITS'(b[3:0]);
              end else begin
                stage_nxt = PS_DONE;
              end
            end
            default: stage_nxt = stage_e;
          endcase
        end

        if (off_r == OFF_LAST) begin
          if (!neg_r && (acc_r != '0)) blk_calc = acc_r - COUNT_BITS'(1);
          blk_nxt = blk_calc;
          if (blk_calc == '0) cmd.nl_cnt = 2'd2;
          else                phase_nxt  = PH_BODY;
        end
      end

      PH_BODY: begin
        if (b == CH_QWKNL) begin
          cmd.has_byte = 1'b1;
          cmd.data     = CH_NL;
        end else if (b != CH_NUL) begin
          cmd.has_byte = 1'b1;
          cmd.data     = b;
        end
        if (off_r == OFF_LAST) begin
          blk_nxt = blk_r - COUNT_BITS'(1);
          if (blk_nxt == '0) begin
            cmd.nl_cnt = 2'd2;
            phase_nxt  = PH_HDR;
          end
        end
      end

      default: begin
        if (off_r == OFF_LAST) phase_nxt = PH_HDR;
      end
    endcase
  end

  assign cmd_o  = cmd;
  assign push_o = accept && ((cmd.lbl != LBL_NONE) || cmd.has_byte || (cmd.nl_cnt != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE;
      off_r   <= '0;
      fend_r  <= 1'b0;
      stage_r <= PS_SKIP;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      blk_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      off_r   <= off_r + 7'd1;
      fend_r  <= fend_nxt;
      stage_r <= stage_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      blk_r   <= blk_nxt;
    end
  end

  a_no_unused_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_UNUSED) else $error("front reached unused phase");

  a_body_has_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> blk_r != '0) else $error("body phase with no blocks left");

endmodule

`default_nettype wire

// File: src/qwk_cmd_queue.sv
// qwk_cmd_queue: small FIFO of commands between front and back.
// Depends on qwk_pkg.
`default_nettype none

module qwk_cmd_queue import qwk_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> !pop) else $error("command queue underflow");

endmodule

`default_nettype wire

// File: src/qwk_back.sv
// qwk_back: expands queued commands into text beats through an output register.
// Depends on qwk_pkg and qwk_out_if.
`default_nettype none

module qwk_back import qwk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  qwk_out_if.source out_ch
);

  logic [2:0] k_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic [2:0] llen;
  logic [3:0] total;
  logic [7:0] ch;
  logic       is_last;
  logic       load;

  assign llen    = label_len(head_cmd.lbl);
  assign total   = {1'b0, llen} + {3'b000, head_cmd.has_byte} + {2'b00, head_cmd.nl_cnt};
  assign is_last = ({1'b0, k_r} == (total - 4'd1));

  always_comb begin
    if (k_r < llen)                                 ch = label_char(head_cmd.lbl, k_r);
    else if (head_cmd.has_byte && (k_r == llen))    ch = head_cmd.data;
    else                                            ch = CH_NL;
  end

  assign load = head_valid && (!out_valid_r || out_ch.ready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        k_r         <= is_last ? 3'd0 : k_r + 3'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= ch;
      out_last_r <= is_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> k_r == 3'd0) else $error("beat index left mid-command");

endmodule

`default_nettype wire
